// File: hdl/bgr_to_uyvy_422_packer_defines.svh
// Assertion macros shared by the BGR to UYVY packer modules.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef BGR_TO_UYVY_422_PACKER_DEFINES_SVH
`define BGR_TO_UYVY_422_PACKER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define B2U_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the same cycle as a trigger.
`define B2U_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define B2U_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/b2u_pkg.sv
// Shared types for the BGR to UYVY 4:2:2 packer.
// No dependencies; used by the front, the queue, the back and the top level.
`timescale 1ns / 1ps

package b2u_pkg;

   // Converted pixel as it waits for the byte serializer.
   typedef struct packed {
      logic       first;   // First pixel of a pair: emits U, Y, V.
      logic [7:0] u;
      logic [7:0] y;
      logic [7:0] v;
   } b2u_entry_type;

   // Queue port: an entry together with its valid flag.
   typedef struct packed {
      logic          valid;
      b2u_entry_type entry;
   } b2u_item_type;

endpackage

// File: hdl/bgr_to_uyvy_422_packer.sv
// Top level of the BGR to UYVY 4:2:2 packer.
// Depends on b2u_pkg, b2u_front, b2u_fifo and b2u_back.
`timescale 1ns / 1ps

// Usage:
// The req channel takes one BGR pixel per word; req_tlast marks the last pixel of an image.
// The rsp channel delivers one packed byte per word in UYVY order. The first pixel of a
// pair gives the words U, Y, V and the second gives Y; chroma comes from the first pixel.
// rsp_tlast is high on the last word that a pixel produces.
// Path: an accepted pixel passes the stage one sums, the stage two products, the queue
// and then the output register before its first word shows on rsp.
// Throughput: the output register moves one word per cycle while rsp_tready is high, and a
// pair of pixels gives four words. The front takes a pixel every cycle while the queue has
// room for it and the pixels still in the conversion stages.
// Reset clears the pair phase, the conversion stage valids, the queue and the output valid;
// the next pixel after reset, or after a pixel with req_tlast, starts a new pair.
// When the receiver holds rsp_tready low, the output word holds, the queue fills, and
// req_tready drops once the queue can take no more pixels.

module bgr_to_uyvy_422_packer #(
   parameter int FIFO_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // blue [7:0], green [15:8], red [23:16]
   input  logic        req_tlast,   // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte [7:0]
   output logic        rsp_tlast    // byte_last
);

   localparam int LVL_W = $clog2(FIFO_DEPTH + 1);

   b2u_pkg::b2u_item_type push;
   b2u_pkg::b2u_item_type head;
   logic                  pop;
   logic [LVL_W-1:0]      level;

   // Conversion front.
   b2u_front #(
      .DEPTH (FIFO_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .level      (level),
      .push       (push)
   );

   // Queue between front and serializer.
   b2u_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .head  (head),
      .pop   (pop),
      .level (level)
   );

   // Byte serializer and output register.
   b2u_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: hdl/b2u_fifo.sv
// Short queue of converted pixels between the conversion front and the byte serializer.
// Depends on b2u_pkg and the assertion macros in bgr_to_uyvy_422_packer_defines.svh.
`timescale 1ns / 1ps
`include "bgr_to_uyvy_422_packer_defines.svh"

module b2u_fifo #(
   parameter int DEPTH = 4,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int LVL_W = $clog2(DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  b2u_pkg::b2u_item_type push,
   output b2u_pkg::b2u_item_type head,
   input  logic                  pop,
   output logic [LVL_W-1:0]      level
);

   b2u_pkg::b2u_entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0]       level_ff, level_in;

   // Pointer and fill-level updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.valid && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (!push.valid && pop) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Storage is written at the tail; no reset needed.
   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

   // The oldest entry is always presented at the head.
   assign head.valid = (level_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];
   assign level      = level_ff;

   `B2U_ASSERT_IMPLIES(a_no_push_when_full, clock, reset, level_ff == LVL_W'(DEPTH), !push.valid, "push into a full queue")
   `B2U_ASSERT_IMPLIES(a_no_pop_when_empty, clock, reset, pop, level_ff != '0, "pop from an empty queue")

endmodule

// File: hdl/b2u_front.sv
// Conversion front: accepts BGR pixels, tracks the pair phase and computes Y, U, V.
// Depends on b2u_pkg; feeds b2u_fifo and throttles on its fill level.
`timescale 1ns / 1ps

module b2u_front #(
   parameter int DEPTH = 4,
   localparam int LVL_W = $clog2(DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,
   input  logic                  req_tlast,
   input  logic [LVL_W-1:0]      level,
   output b2u_pkg::b2u_item_type push
);

   // Sums are in units of 1/1000 with the half-up rounding term folded in.
   localparam int SUM_W  = 19;
   localparam int X_W    = SUM_W - 1;
   localparam int PROD_W = 37;
   localparam int SHIFT  = 28;
   localparam logic [18:0] RECIP = 19'd268436;   // ceil(2^28 / 1000)

   localparam logic signed [SUM_W-1:0] C_YR  = 19'sd257;
   localparam logic signed [SUM_W-1:0] C_YG  = 19'sd504;
   localparam logic signed [SUM_W-1:0] C_YB  = 19'sd98;
   localparam logic signed [SUM_W-1:0] C_YO  = 19'sd16500;
   localparam logic signed [SUM_W-1:0] C_UR  = -19'sd148;
   localparam logic signed [SUM_W-1:0] C_UG  = -19'sd291;
   localparam logic signed [SUM_W-1:0] C_UB  = 19'sd439;
   localparam logic signed [SUM_W-1:0] C_VR  = 19'sd439;
   localparam logic signed [SUM_W-1:0] C_VG  = -19'sd368;
   localparam logic signed [SUM_W-1:0] C_VB  = -19'sd71;
   localparam logic signed [SUM_W-1:0] C_UVO = 19'sd128500;

   logic                       req_accept;
   logic [LVL_W:0]             inflight;
   logic                       phase_ff, phase_in;
   logic signed [SUM_W-1:0]    r_ext, g_ext, b_ext;
   logic                       s1_valid_ff, s2_valid_ff;
   logic                       s1_first_ff, s2_first_ff;
   logic signed [SUM_W-1:0]    y_sum_ff, u_sum_ff, v_sum_ff;
   logic signed [SUM_W-1:0]    y_sum_in, u_sum_in, v_sum_in;
   logic [X_W-1:0]             y_x, u_x, v_x;
   logic [PROD_W-1:0]          y_prod_ff, u_prod_ff, v_prod_ff;
   logic [PROD_W-1:0]          y_prod_in, u_prod_in, v_prod_in;

   // Quotient by 1000 from the reciprocal product, saturated to a byte.
   function automatic logic [7:0] sat_byte(input logic [PROD_W-1:0] p);
      logic [PROD_W-SHIFT-1:0] q;
      q = p[PROD_W-1:SHIFT];
      return q[8] ? 8'hFF : q[7:0];
   endfunction

   // Take a pixel only when the queue has room for everything in flight.
   assign inflight   = {1'b0, level} + (LVL_W + 1)'(s1_valid_ff) + (LVL_W + 1)'(s2_valid_ff);
   assign req_tready = (inflight < (LVL_W + 1)'(DEPTH));
   assign req_accept = req_tvalid && req_tready;

   // Pair phase toggles per pixel and returns to the first pixel after frame end.
   assign phase_in = req_tlast ? 1'b0 : ~phase_ff;

   // Stage one: the three weighted sums.
   always_comb begin
      b_ext    = SUM_W'(req_tdata[7:0]);
      g_ext    = SUM_W'(req_tdata[15:8]);
      r_ext    = SUM_W'(req_tdata[23:16]);
      y_sum_in = C_YR * r_ext + C_YG * g_ext + C_YB * b_ext + C_YO;
      u_sum_in = C_UR * r_ext + C_UG * g_ext + C_UB * b_ext + C_UVO;
      v_sum_in = C_VR * r_ext + C_VG * g_ext + C_VB * b_ext + C_UVO;
   end

   // Stage two: negative sums clamp to zero, then multiply by the reciprocal.
   always_comb begin
      y_x       = y_sum_ff[SUM_W-1] ? '0 : y_sum_ff[X_W-1:0];
      u_x       = u_sum_ff[SUM_W-1] ? '0 : u_sum_ff[X_W-1:0];
      v_x       = v_sum_ff[SUM_W-1] ? '0 : v_sum_ff[X_W-1:0];
      y_prod_in = PROD_W'(y_x) * PROD_W'(RECIP);
      u_prod_in = PROD_W'(u_x) * PROD_W'(RECIP);
      v_prod_in = PROD_W'(v_x) * PROD_W'(RECIP);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            phase_ff <= phase_in;
         end
         s1_valid_ff <= req_accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Datapath registers; the pipeline never stalls.
   always_ff @(posedge clock) begin
      s1_first_ff <= ~phase_ff;
      y_sum_ff    <= y_sum_in;
      u_sum_ff    <= u_sum_in;
      v_sum_ff    <= v_sum_in;
      s2_first_ff <= s1_first_ff;
      y_prod_ff   <= y_prod_in;
      u_prod_ff   <= u_prod_in;
      v_prod_ff   <= v_prod_in;
   end

   // Stage three: the bytes go straight into the queue.
   assign push.valid       = s2_valid_ff;
   assign push.entry.first = s2_first_ff;
   assign push.entry.u     = sat_byte(u_prod_ff);
   assign push.entry.y     = sat_byte(y_prod_ff);
   assign push.entry.v     = sat_byte(v_prod_ff);

endmodule

// File: hdl/b2u_back.sv
// Byte serializer: walks each queued pixel as U, Y, V or as a lone Y into the output register.
// Depends on b2u_pkg and the assertion macros in bgr_to_uyvy_422_packer_defines.svh.
`timescale 1ns / 1ps
`include "bgr_to_uyvy_422_packer_defines.svh"

module b2u_back (
   input  logic                  clock,
   input  logic                  reset,
   input  b2u_pkg::b2u_item_type head,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tlast
);

   typedef enum logic [1:0] {
      POS_FIRST,
      POS_SECOND,
      POS_THIRD
   } pos_type;

   pos_type    pos_ff, pos_in;
   logic       rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0] rsp_tdata_ff, rsp_tdata_in;
   logic       rsp_tlast_ff, rsp_tlast_in;
   logic       load;
   logic [7:0] sel_byte;
   logic       sel_last;
   pos_type    pos_next;

   // The output register takes a new word when empty or being drained.
   assign load = !rsp_tvalid_ff || rsp_tready;

   // Pick the byte for the current position of the head pixel.
   always_comb begin
      sel_byte = head.entry.y;
      sel_last = 1'b1;
      pos_next = POS_FIRST;
      if (head.entry.first) begin
         case (pos_ff)
            POS_FIRST: begin
               sel_byte = head.entry.u;
               sel_last = 1'b0;
               pos_next = POS_SECOND;
            end
            POS_SECOND: begin
               sel_byte = head.entry.y;
               sel_last = 1'b0;
               pos_next = POS_THIRD;
            end
            POS_THIRD: begin
               sel_byte = head.entry.v;
               sel_last = 1'b1;
               pos_next = POS_FIRST;
            end
            default: begin
               sel_byte = head.entry.y;
               sel_last = 1'b1;
               pos_next = POS_FIRST;
            end
         endcase
      end
   end

   // Next-state and output-word logic.
   always_comb begin
      pos_in        = pos_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      if (load) begin
         rsp_tvalid_in = head.valid;
         if (head.valid) begin
            rsp_tdata_in = sel_byte;
            rsp_tlast_in = sel_last;
            pos_in       = pos_next;
         end
      end
   end

   // Release the head pixel together with its last byte.
   assign pop = load && head.valid && sel_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= POS_FIRST;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   `B2U_ASSERT_NEXT(a_stall_holds_pos, clock, reset, rsp_tvalid_ff && !rsp_tready, $stable(pos_ff), "byte position moved during a stall")
   `B2U_ASSERT_NEXT(a_pop_loads_last, clock, reset, pop, rsp_tvalid_ff && rsp_tlast_ff && pos_ff == POS_FIRST, "pixel released without its last word")

endmodule

// File: sim/bgr_to_uyvy_422_packer_tb.sv
// Self-checking testbench for the BGR to UYVY 4:2:2 packer.
// Needs only the bgr_to_uyvy_422_packer RTL; it has its own BT.601 byte predictor.
`timescale 1ns / 1ps

module bgr_to_uyvy_422_packer_tb;

   localparam int CLK_HALF    = 2;
   localparam int RESET_CYCLES = 9;
   localparam int RAND_PIXELS = 260;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_MAX  = 10;
   localparam int DIR_ROWS    = 16;

   // One pixel of stimulus; when known is set, ty/tu/tv are the hand-worked bytes.
   typedef struct packed {
      logic [7:0] b;
      logic [7:0] g;
      logic [7:0] r;
      logic       fe;
      logic       known;
      logic [7:0] ty;
      logic [7:0] tu;
      logic [7:0] tv;
   } pixel_row_type;

   // One byte that the packer is due to emit.
   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } uyvy_byte_type;

   typedef struct packed {
      logic [7:0] y;
      logic [7:0] u;
      logic [7:0] v;
   } yuv_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // blue [7:0], green [15:8], red [23:16]
   logic        req_tlast = 1'b0; // frame_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // out_byte [7:0]
   logic        rsp_tlast;        // byte_last

   uyvy_byte_type bytes_due[$];
   logic        pair_second = 1'b0;
   logic        no_idle = 1'b0;
   logic        hold_out = 1'b0;
   int          rx_stall = 0;
   int          error_cnt = 0;
   int          cycle_cnt = 0;

   // Directed rows: primaries and extremes typed in, then mixed values from the predictor.
   pixel_row_type dir_rows [0:DIR_ROWS-1] = '{
      '{8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'd16,  8'd128, 8'd128},  // black, first
      '{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 8'd235, 8'd128, 8'd128},  // white, second
      '{8'h00, 8'h00, 8'hFF, 1'b1, 1'b1, 8'd82,  8'd90,  8'd240},  // red, unpaired end
      '{8'h00, 8'hFF, 8'h00, 1'b0, 1'b1, 8'd145, 8'd54,  8'd34},   // green, first
      '{8'hFF, 8'h00, 8'h00, 1'b1, 1'b1, 8'd41,  8'd240, 8'd110},  // blue, paired end
      '{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 8'd235, 8'd128, 8'd128},
      '{8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'd16,  8'd128, 8'd128},
      '{8'hFF, 8'h00, 8'h00, 1'b0, 1'b1, 8'd41,  8'd240, 8'd110},
      '{8'h00, 8'h00, 8'hFF, 1'b0, 1'b1, 8'd82,  8'd90,  8'd240},
      '{8'h00, 8'hFF, 8'h00, 1'b1, 1'b1, 8'd145, 8'd54,  8'd34},
      '{8'h80, 8'h80, 8'h80, 1'b1, 1'b0, 8'd0,   8'd0,   8'd0},
      '{8'h12, 8'h34, 8'h56, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
      '{8'hAA, 8'h55, 8'hF0, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
      '{8'h01, 8'hFE, 8'h7F, 1'b1, 1'b0, 8'd0,   8'd0,   8'd0},
      '{8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
      '{8'h00, 8'hFF, 8'h00, 1'b1, 1'b0, 8'd0,   8'd0,   8'd0}
   };

   bgr_to_uyvy_422_packer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #CLK_HALF clock = ~clock;

   // Rounds a sum in thousandths half up and clamps it to a byte.
   function automatic logic [7:0] milli_to_byte(input int sum);
      int v;
      if (sum < 0) return 8'd0;
      v = (sum + 500) / 1000;
      if (v > 255) v = 255;
      return v[7:0];
   endfunction

   // BT.601 studio-range conversion with coefficients in thousandths.
   function automatic yuv_type bt601_convert(input logic [7:0] b, g, r);
      yuv_type c;
      int      bi, gi, ri;
      bi  = int'(b);
      gi  = int'(g);
      ri  = int'(r);
      c.y = milli_to_byte(257 * ri + 504 * gi + 98 * bi + 16000);
      c.u = milli_to_byte(-148 * ri - 291 * gi + 439 * bi + 128000);
      c.v = milli_to_byte(439 * ri - 368 * gi - 71 * bi + 128000);
      return c;
   endfunction

   // Idle length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Channel value biased toward the extremes.
   function automatic logic [7:0] rand_channel();
      int roll;
      roll = $urandom_range(0, 7);
      if (roll == 0) return 8'h00;
      if (roll == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic flag_error(input string msg);
      if (error_cnt < REPORT_MAX) $display("%0t: %s", $realtime, msg);
      error_cnt++;
   endtask

   // Queues the bytes an accepted pixel causes and advances the pair phase.
   task automatic queue_pixel_bytes(input pixel_row_type px);
      yuv_type c;
      c = bt601_convert(px.b, px.g, px.r);
      if (px.known) begin
         c.y = px.ty;
         c.u = px.tu;
         c.v = px.tv;
      end
      if (!pair_second) begin
         bytes_due.push_back(uyvy_byte_type'{c.u, 1'b0});
         bytes_due.push_back(uyvy_byte_type'{c.y, 1'b0});
         bytes_due.push_back(uyvy_byte_type'{c.v, 1'b1});
      end else begin
         bytes_due.push_back(uyvy_byte_type'{c.y, 1'b1});
      end
      pair_second = px.fe ? 1'b0 : ~pair_second;
   endtask

   // Offers one pixel word after a random gap and waits for it to be taken.
   task automatic send_pixel(input pixel_row_type px);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {px.r, px.g, px.b};
      req_tlast  = px.fe;
      do @(posedge clock); while (!req_tready);
      queue_pixel_bytes(px);
   endtask

   // Receiver: random stalls, plus one long hold-off when asked for.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_out) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_out = 1'b0;
         end else if (rx_stall > 0) begin
            rsp_tready = 1'b0;
            rx_stall--;
         end else begin
            rsp_tready = 1'b1;
            rx_stall = pick_gap();
         end
      end
   end

   // Compare every accepted byte with the oldest one due.
   always @(posedge clock) begin
      uyvy_byte_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (bytes_due.size() == 0) begin
            flag_error($sformatf("unexpected byte %02h last %0b", rsp_tdata, rsp_tlast));
         end else begin
            due = bytes_due.pop_front();
            if (rsp_tdata !== due.value || rsp_tlast !== due.last)
               flag_error($sformatf("byte exp %02h last %0b, got %02h last %0b",
                                    due.value, due.last, rsp_tdata, rsp_tlast));
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Main sequence: reset, directed rows, random pixels, drain.
   initial begin
      pixel_row_type px;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) send_pixel(dir_rows[i]);

      for (int i = 0; i < RAND_PIXELS; i++) begin
         if (i == 80) hold_out = 1'b1;
         no_idle  = (i >= 150 && i < 190);
         px.b     = rand_channel();
         px.g     = rand_channel();
         px.r     = rand_channel();
         px.fe    = ($urandom_range(0, 9) == 0);
         px.known = 1'b0;
         px.ty    = '0;
         px.tu    = '0;
         px.tv    = '0;
         send_pixel(px);
      end
      no_idle = 1'b0;

      @(negedge clock);
      req_tvalid = 1'b0;
      req_tlast  = 1'b0;
      while (bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_cnt == 0 && bytes_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
